// ===== rtl/pfe_pkg.sv =====
// Shared types and constants for the postfix expression evaluator.
// No dependencies; imported by every other RTL file of the block except pfe_ram.
`timescale 1ns / 1ps
`default_nettype none
package pfe_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int AW          = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DW          = 32;
  localparam int DIV_STEPS   = DW;
  localparam int DCNT_W      = $clog2(DIV_STEPS);

  localparam logic [7:0] SYM_END   = 8'd0;
  localparam logic [7:0] SYM_ZERO  = 8'd48;
  localparam logic [7:0] SYM_NINE  = 8'd57;
  localparam logic [7:0] SYM_POW   = 8'h5E;
  localparam logic [7:0] SYM_MUL   = 8'h2A;
  localparam logic [7:0] SYM_DIV   = 8'h2F;
  localparam logic [7:0] SYM_ADD   = 8'h2B;
  localparam logic [7:0] SYM_SUB   = 8'h2D;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_UNDER = 2'd1;
  localparam logic [1:0] ERR_OVER  = 2'd2;
  localparam logic [1:0] ERR_DIVZ  = 2'd3;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_POW = 3'd4;

  typedef struct packed {
    logic          start;
    logic [2:0]    op;
    logic [DW-1:0] left;
    logic [DW-1:0] right;
  } alu_req_t;

  typedef struct packed {
    logic          done;
    logic          divz;
    logic [DW-1:0] result;
  } alu_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/pfe_if.sv =====
// Channel interfaces for the postfix evaluator: symbol input and result output.
// Depends on pfe_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface pfe_in_if import pfe_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  modport source (output valid, output symbol, input ready);
  modport sink   (input valid, input symbol, output ready);
endinterface

interface pfe_out_if import pfe_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] value;
  logic [1:0]           error_code;
  modport source (output valid, output value, output error_code, input ready);
  modport sink   (input valid, input value, input error_code, output ready);
endinterface
`default_nettype wire

// ===== rtl/pfe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none
module pfe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/pfe_alu.sv =====
// Shared iterative arithmetic unit: add, subtract, multiply, restoring divide,
// square-and-multiply power on one multiplier. Depends on pfe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pfe_alu import pfe_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire alu_req_t req,
  output alu_rsp_t      rsp
);
  localparam logic [1:0] A_IDLE = 2'd0;
  localparam logic [1:0] A_DIV  = 2'd1;
  localparam logic [1:0] A_POW  = 2'd2;
  localparam logic [1:0] A_DONE = 2'd3;

  logic [1:0]        st_r, st_nxt;
  logic [DW-1:0]     acc_r, acc_nxt;    // power accumulator / quotient
  logic [DW-1:0]     base_r, base_nxt;  // power base / divisor
  logic [DW-1:0]     expo_r, expo_nxt;
  logic [DW:0]       rem_r, rem_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic              phase_r, phase_nxt;
  logic              neg_r, neg_nxt;
  logic              divz_r, divz_nxt;
  logic [DW-1:0]     res_r, res_nxt;

  logic [DW-1:0]     mul_x, mul_y;
  logic [2*DW-1:0]   prod;
  logic [DW:0]       shifted, trial;
  logic [DW-1:0]     abs_l, abs_r;

  assign prod    = mul_x * mul_y;
  assign shifted = {rem_r[DW-1:0], acc_r[DW-1]};
  assign trial   = shifted - {1'b0, base_r};
  assign abs_l   = req.left[DW-1]  ? (~req.left + 1'b1)  : req.left;
  assign abs_r   = req.right[DW-1] ? (~req.right + 1'b1) : req.right;

  always_comb begin
    mul_x = req.left;
    mul_y = req.right;
    if (st_r == A_POW) begin
      mul_x = phase_r ? base_r : acc_r;
      mul_y = base_r;
    end
  end

  always_comb begin
    st_nxt    = st_r;
    acc_nxt   = acc_r;
    base_nxt  = base_r;
    expo_nxt  = expo_r;
    rem_nxt   = rem_r;
    dcnt_nxt  = dcnt_r;
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    divz_nxt  = divz_r;
    res_nxt   = res_r;
    unique case (st_r)
      A_IDLE: begin
        if (req.start) begin
          divz_nxt = 1'b0;
          st_nxt   = A_DONE;
          unique case (req.op)
            OP_ADD: res_nxt = req.left + req.right;
            OP_SUB: res_nxt = req.left - req.right;
            OP_MUL: res_nxt = prod[DW-1:0];
            OP_DIV: begin
              if (req.right == '0) begin
                res_nxt  = '0;
                divz_nxt = 1'b1;
              end else begin
                rem_nxt  = '0;
                acc_nxt  = abs_l;
                base_nxt = abs_r;
                neg_nxt  = req.left[DW-1] ^ req.right[DW-1];
                dcnt_nxt = DCNT_W'(DIV_STEPS - 1);
                st_nxt   = A_DIV;
              end
            end
            OP_POW: begin
              if (req.right[DW-1]) begin
                // negative exponent: truncated reciprocal
                if (req.left == '0) begin
                  res_nxt  = '0;
                  divz_nxt = 1'b1;
                end else if (req.left == DW'(1)) begin
                  res_nxt = DW'(1);
                end else if (req.left == '1) begin
                  res_nxt = req.right[0] ? '1 : DW'(1);
                end else begin
                  res_nxt = '0;
                end
              end else begin
                acc_nxt   = DW'(1);
                base_nxt  = req.left;
                expo_nxt  = req.right;
                phase_nxt = 1'b0;
                st_nxt    = A_POW;
              end
            end
            default: res_nxt = '0;
          endcase
        end
      end
      A_DIV: begin
        if (!trial[DW]) begin
          rem_nxt = trial;
          acc_nxt = {acc_r[DW-2:0], 1'b1};
        end else begin
          rem_nxt = shifted;
          acc_nxt = {acc_r[DW-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r - 1'b1;
        if (dcnt_r == '0) begin
          res_nxt = neg_r ? (~acc_nxt + 1'b1) : acc_nxt;
          st_nxt  = A_DONE;
        end
      end
      A_POW: begin
        if (expo_r == '0) begin
          res_nxt = acc_r;
          st_nxt  = A_DONE;
        end else if (!phase_r) begin
          if (expo_r[0]) begin
            acc_nxt = prod[DW-1:0];
          end
          phase_nxt = 1'b1;
        end else begin
          base_nxt  = prod[DW-1:0];
          expo_nxt  = expo_r >> 1;
          phase_nxt = 1'b0;
        end
      end
      A_DONE: st_nxt = A_IDLE;
      default: st_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= A_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    acc_r   <= acc_nxt;
    base_r  <= base_nxt;
    expo_r  <= expo_nxt;
    rem_r   <= rem_nxt;
    dcnt_r  <= dcnt_nxt;
    phase_r <= phase_nxt;
    neg_r   <= neg_nxt;
    divz_r  <= divz_nxt;
    res_r   <= res_nxt;
  end

  assign rsp.done   = (st_r == A_DONE);
  assign rsp.divz   = divz_r;
  assign rsp.result = res_r;
endmodule
`default_nettype wire

// ===== rtl/postfix_expression_evaluator_unit.sv =====
// Top level of the postfix expression evaluator: sequencer, operand stack
// RAM and shared arithmetic unit. Depends on pfe_pkg, pfe_if, pfe_ram, pfe_alu.
//
// One ASCII postfix symbol per input transaction. A digit is pushed when it
// is accepted and the next symbol can follow immediately. An operator reads its
// two operands from the stack RAM (one read port, registered read), then runs
// on the shared arithmetic unit: + - * are computed directly, / uses a 32-step
// restoring divider and ^ uses square-and-multiply on the one 32x32 multiplier.
// Any other symbol drops two operands. A zero symbol ends the expression: the
// top value is read and one result transaction carries it with the sticky
// error code, after which stack and error clear. The result sits in an output
// register, so digits keep being taken while a result waits; only the next end
// symbol stalls on it. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module postfix_expression_evaluator_unit import pfe_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pfe_in_if.sink     in_ch,
  pfe_out_if.source  out_ch
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD_R = 3'd1;  // right operand on RAM output
  localparam logic [2:0] S_RD_L = 3'd2;  // left operand on RAM output, start ALU
  localparam logic [2:0] S_WAIT = 3'd3;  // waiting on ALU, then push
  localparam logic [2:0] S_TRD  = 3'd4;  // top value on RAM output
  localparam logic [2:0] S_OUTW = 3'd5;  // load output register when free

  logic [2:0]      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]      err_r, err_nxt;
  logic [2:0]      op_r, op_nxt;
  logic [DW-1:0]   right_r, right_nxt;
  logic [DW-1:0]   hold_r, hold_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [DW-1:0]   out_value_r, out_value_nxt;
  logic [1:0]      out_err_r, out_err_nxt;

  logic            accept, is_digit, out_free;
  logic [CNT_W-1:0] cnt_m1, cnt_m2;
  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [DW-1:0]   ram_wdata, ram_rdata;
  alu_req_t        alu_req;
  alu_rsp_t        alu_rsp;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_digit    = (in_ch.symbol >= SYM_ZERO) && (in_ch.symbol <= SYM_NINE);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign cnt_m1      = cnt_r - 1'b1;
  assign cnt_m2      = cnt_r - CNT_W'(2);

  pfe_ram #(.WIDTH(DW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pfe_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    op_nxt        = op_r;
    right_nxt     = right_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_value_nxt = out_value_r;
    out_err_nxt   = out_err_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r[AW-1:0];
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = cnt_m1[AW-1:0];
    alu_req       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.symbol == SYM_END) begin
            if (cnt_r == '0) begin
              hold_nxt  = '0;
              err_nxt   = (err_r == ERR_NONE) ? ERR_UNDER : err_r;
              state_nxt = S_OUTW;
            end else begin
              ram_re    = 1'b1;
              state_nxt = S_TRD;
            end
          end else if (is_digit) begin
            if (cnt_r == CNT_W'(STACK_DEPTH)) begin
              err_nxt = (err_r == ERR_NONE) ? ERR_OVER : err_r;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = DW'(in_ch.symbol - SYM_ZERO);
              cnt_nxt   = cnt_r + 1'b1;
            end
          end else if (cnt_r < CNT_W'(2)) begin
            err_nxt = (err_r == ERR_NONE) ? ERR_UNDER : err_r;
          end else begin
            unique case (in_ch.symbol)
              SYM_POW: op_nxt = OP_POW;
              SYM_MUL: op_nxt = OP_MUL;
              SYM_DIV: op_nxt = OP_DIV;
              SYM_ADD: op_nxt = OP_ADD;
              SYM_SUB: op_nxt = OP_SUB;
              default: op_nxt = op_r;
            endcase
            if (in_ch.symbol == SYM_POW || in_ch.symbol == SYM_MUL ||
                in_ch.symbol == SYM_DIV || in_ch.symbol == SYM_ADD ||
                in_ch.symbol == SYM_SUB) begin
              ram_re    = 1'b1;
              state_nxt = S_RD_R;
            end else begin
              cnt_nxt = cnt_m2;  // unknown symbol: drop both operands
            end
          end
        end
      end
      S_RD_R: begin
        right_nxt = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = cnt_m2[AW-1:0];
        state_nxt = S_RD_L;
      end
      S_RD_L: begin
        alu_req.start = 1'b1;
        alu_req.op    = op_r;
        alu_req.left  = ram_rdata;
        alu_req.right = right_r;
        state_nxt     = S_WAIT;
      end
      S_WAIT: begin
        if (alu_rsp.done) begin
          // two popped, one pushed: never overflows
          ram_we    = 1'b1;
          ram_waddr = cnt_m2[AW-1:0];
          ram_wdata = alu_rsp.result;
          cnt_nxt   = cnt_m1;
          if (alu_rsp.divz && err_r == ERR_NONE) begin
            err_nxt = ERR_DIVZ;
          end
          state_nxt = S_IDLE;
        end
      end
      S_TRD: begin
        hold_nxt  = ram_rdata;
        state_nxt = S_OUTW;
      end
      S_OUTW: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = hold_r;
          out_err_nxt   = err_r;
          cnt_nxt       = '0;
          err_nxt       = ERR_NONE;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      err_r       <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    right_r     <= right_nxt;
    hold_r      <= hold_nxt;
    out_value_r <= out_value_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.value      = $signed(out_value_r);
  assign out_ch.error_code = out_err_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_alu_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> state_r == S_WAIT)
    else $error("ALU completion outside wait state");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUTW && out_free) |=> (cnt_r == '0 && err_r == ERR_NONE && out_valid_r))
    else $error("end of expression did not clear stack");

  a_no_push_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT && alu_rsp.done) |-> cnt_r >= CNT_W'(2))
    else $error("push of result without two popped operands");
`endif
endmodule
`default_nettype wire
